FILE: src/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_PLUS    = 7'h2B;
  localparam logic [6:0] CHAR_SLASH   = 7'h2F;
  localparam logic [6:0] CHAR_PAD     = 7'h3D;

  // group byte counts
  localparam logic [1:0] NBYTES_ONE   = 2'd1;
  localparam logic [1:0] NBYTES_TWO   = 2'd2;
  localparam logic [1:0] NBYTES_THREE = 2'd3;

  // character slots within a group
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;
  localparam logic [1:0] SLOT_FOURTH = 2'd3;

  typedef struct packed {
    logic [23:0] word;    // first byte in bits 23..16
    logic [1:0]  nbytes;  // 1..3
    logic        last;    // group closed by the final byte
  } b64e_group_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] slot;
  } b64e_back_stat_t;

  function automatic logic [6:0] b64_char(input logic [5:0] s);
    logic [6:0] v;
    v = {1'b0, s};
    if (s < 6'd26) begin
      return CHAR_UPPER_A + v;
    end else if (s < 6'd52) begin
      return CHAR_LOWER_A + v - 7'd26;
    end else if (s < 6'd62) begin
      return CHAR_ZERO + v - 7'd52;
    end else if (s == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/b64e_front.sv
`default_nettype none
module b64e_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
  input  wire logic                s_tlast,   // last_byte
  output logic                     q_push,
  output b64e_pkg::b64e_group_t    q_data,
  input  wire logic                q_full
);
  import b64e_pkg::*;

  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic        take;
  logic        close;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;
  assign close    = s_tlast || (held_count >= 2'd2);
  assign q_push   = take && close;

  always_comb begin
    q_data.last = s_tlast;
    case (held_count)
      2'd0: begin
        q_data.word   = {s_tdata, 16'h0000};
        q_data.nbytes = NBYTES_ONE;
      end
      2'd1: begin
        q_data.word   = {held_bytes[15:8], s_tdata, 8'h00};
        q_data.nbytes = NBYTES_TWO;
      end
      default: begin
        q_data.word   = {held_bytes, s_tdata};
        q_data.nbytes = NBYTES_THREE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= 16'h0000;
      held_count <= 2'd0;
    end else if (take) begin
      if (close) begin
        held_bytes <= 16'h0000;
        held_count <= 2'd0;
      end else if (held_count == 2'd0) begin
        held_bytes <= {s_tdata, 8'h00};
        held_count <= 2'd1;
      end else begin
        held_bytes <= {held_bytes[15:8], s_tdata};
        held_count <= 2'd2;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/b64e_queue.sv
`default_nettype none
module b64e_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire b64e_pkg::b64e_group_t push_data,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       avail,
  output b64e_pkg::b64e_group_t      head
);
  import b64e_pkg::*;

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  b64e_group_t             slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (count == CNT_FULL);
  assign avail   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/b64e_back.sv
`default_nettype none
module b64e_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_avail,
  input  wire b64e_pkg::b64e_group_t q_head,
  output logic                       q_pop,
  output b64e_pkg::b64e_back_stat_t  stat,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,  // [6:0] out_char, [7] zero
  output logic                       m_tlast   // last_char
);
  import b64e_pkg::*;

  b64e_group_t cur;
  logic        busy;
  logic [1:0]  slot;
  logic        advance;
  logic        done;
  logic [5:0]  sextet;
  logic        pad;
  logic [6:0]  ch;

  // output register free or draining this cycle
  assign advance = busy && (!m_tvalid || m_tready);
  assign done    = advance && (slot == SLOT_FOURTH);
  assign q_pop   = q_avail && (!busy || done);

  assign stat = '{busy: busy, slot: slot};

  always_comb begin
    case (slot)
      SLOT_FIRST: begin
        sextet = cur.word[23:18];
        pad    = 1'b0;
      end
      SLOT_SECOND: begin
        sextet = cur.word[17:12];
        pad    = 1'b0;
      end
      SLOT_THIRD: begin
        sextet = cur.word[11:6];
        pad    = (cur.nbytes == NBYTES_ONE);
      end
      default: begin
        sextet = cur.word[5:0];
        pad    = (cur.nbytes != NBYTES_THREE);
      end
    endcase
    ch = pad ? CHAR_PAD : b64_char(sextet);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (advance) begin
      m_tdata <= {1'b0, ch};
      m_tlast <= cur.last && (slot == SLOT_FOURTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      slot     <= SLOT_FIRST;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        slot <= SLOT_FIRST;
      end else if (done) begin
        busy <= 1'b0;
        slot <= SLOT_FIRST;
      end else if (advance) begin
        slot <= slot + 1'b1;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/base64_stream_encoder_core.sv
`default_nettype none
// Channel   Dir  tdata              tuser  tlast
// s_*       in   [7:0] data_byte    -      last_byte
// m_*       out  [6:0] out_char     -      last_char
//
// Each input transaction is accepted while s_tready is high; s_tready drops only while the
// two-entry group queue is full.
// The back end emits one character per cycle while m_tready allows, four per group,
// a padded short final group included.
// A closing byte passes through the group queue and the back end's group register
// before m_tvalid rises. rst is synchronous: held bytes, queue pointers and count, and m_tvalid clear.
// A stall on m_tready backs up the queue and then s_tready.
module base64_stream_encoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [6:0] out_char, [7] zero
  output logic            m_tlast    // last_char
);
  import b64e_pkg::*;

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_avail;
  b64e_group_t     q_in;
  b64e_group_t     q_head;
  b64e_back_stat_t back_stat;

  // front: gathers bytes into groups of up to three
  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  // decouples byte intake from character output
  b64e_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // back: turns a group into four characters, pads short groups
  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .stat     (back_stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // a group is never pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("group pushed into full queue");

  // an idle back end sits at the first slot
  assert property (@(posedge clk) disable iff (rst)
    !back_stat.busy |-> (back_stat.slot == SLOT_FIRST))
    else $error("back end idle at nonzero slot");

  // pop happens only when the back end can take a group
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_avail && (!back_stat.busy || back_stat.slot == SLOT_FOURTH)))
    else $error("queue popped while back end busy");

  // characters are 7-bit ASCII
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !m_tdata[7])
    else $error("output character above 7 bits");

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
module tb;
  import b64e_pkg::*;

  // Standard base64 alphabet, index 0 in the top byte.
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] ch;
    logic       lst;
  } enc_char_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          typed;   // expected group typed in below
    logic [31:0] chars;   // four ASCII chars, first in the top byte
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  base64_stream_encoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Encoder shadow state: pending bytes of the open group.
  logic [7:0] held_first = 8'h00;
  logic [7:0] held_second = 8'h00;
  logic [1:0] held_n = 2'd0;

  enc_char_t   pending_chars[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned groups_closed = 0;

  // Idle knobs, percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          send_calm = 1'b0;
  int unsigned recv_run = 0;
  bit          recv_calm = 1'b0;
  enc_char_t   got_want;

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h (t=%0t)", what, want_v, got_v, $time);
    mismatches++;
  endtask

  function automatic logic [6:0] sextet_to_char(input logic [5:0] s);
    return B64_ALPHABET[8*(63 - s) +: 7];
  endfunction

  // Advance the shadow state by one byte. When the byte closes a group,
  // closes=1 and chars holds the four characters, first in bits 27..21.
  task automatic encode_byte(input logic [7:0] b, input logic l,
                             output bit closes, output logic [27:0] chars);
    logic [1:0]  cnt;
    logic [23:0] word;
    logic [6:0]  c2;
    logic [6:0]  c3;
    cnt = (held_n > 2'd2) ? 2'd2 : held_n;
    closes = 1'b0;
    chars = '0;
    if (cnt < 2'd2 && !l) begin
      // group still open: just stash the byte
      if (cnt == 2'd0) held_first = b;
      else held_second = b;
      held_n = cnt + 2'd1;
    end else begin
      case (cnt)
        2'd0:    word = {b, 16'h0000};
        2'd1:    word = {held_first, b, 8'h00};
        default: word = {held_first, held_second, b};
      endcase
      // short final groups pad the tail, regardless of sextet value
      c2 = (cnt >= 2'd1) ? sextet_to_char(word[11:6]) : CHAR_PAD;
      c3 = (cnt >= 2'd2) ? sextet_to_char(word[5:0]) : CHAR_PAD;
      chars = {sextet_to_char(word[23:18]), sextet_to_char(word[17:12]), c2, c3};
      closes = 1'b1;
      held_first = 8'h00;
      held_second = 8'h00;
      held_n = 2'd0;
    end
  endtask

  // One input transaction, with optional idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                           input logic [31:0] typed_chars);
    bit         closes;
    logic [27:0] chars;
    logic [6:0] c;
    int         k;
    while (!send_calm && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    encode_byte(b, l, closes, chars);
    if (closes) begin
      groups_closed++;
      for (k = 0; k < 4; k++) begin
        c = typed ? typed_chars[8*(3 - k) +: 7] : chars[7*(3 - k) +: 7];
        pending_chars.push_back('{ch: c, lst: (k == 3) && l});
      end
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic l, input bit typed,
                         input logic [31:0] chars);
    stim_row_t r;
    r.data = b;
    r.last = l;
    r.typed = typed;
    r.chars = chars;
    directed_rows.push_back(r);
  endtask

  // Random messages of random length, final byte flagged.
  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned nbytes);
    int unsigned sent;
    int unsigned len;
    int unsigned i;
    logic [7:0]  b;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    sent = 0;
    while (sent < nbytes) begin
      // mostly short messages so every tail length shows up often
      len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_calm = ($urandom_range(3) == 0);
      for (i = 0; i < len; i++) begin
        case ($urandom_range(9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = $urandom_range(255);
        endcase
        send_byte(b, i == len - 1, 1'b0, '0);
      end
      sent += len;
    end
    send_calm = 1'b0;
  endtask

  // Receiver backpressure: runs of random stalls, with calm stretches between.
  always @(posedge clk) begin
    if (recv_run == 0) begin
      recv_run <= $urandom_range(1, 40);
      recv_calm <= ($urandom_range(3) == 0);
    end else begin
      recv_run <= recv_run - 1;
    end
    if (rst || recv_calm || recv_stall_pct == 0) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output checker: each output transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("character with nothing pending", 0, m_tdata);
      end else begin
        got_want = pending_chars.pop_front();
        chars_checked++;
        if (m_tdata !== {1'b0, got_want.ch})
          report_mismatch("out_char", {1'b0, got_want.ch}, m_tdata);
        if (m_tlast !== got_want.lst)
          report_mismatch("last_char", got_want.lst, m_tlast);
      end
    end
  end

  initial begin
    int unsigned guard;
    int          r;

    // Directed groups; expected text is standard base64.
    add_row("M", 1'b1, 1'b1, "TQ==");       // single-byte message
    add_row("M", 1'b0, 1'b0, '0);
    add_row("a", 1'b1, 1'b1, "TWE=");       // two-byte message
    add_row("M", 1'b0, 1'b0, '0);
    add_row("a", 1'b0, 1'b0, '0);
    add_row("n", 1'b0, 1'b1, "TWFu");       // full group, message continues
    add_row("M", 1'b0, 1'b0, '0);
    add_row("a", 1'b0, 1'b0, '0);
    add_row("n", 1'b1, 1'b1, "TWFu");       // full group closing the message
    add_row(8'h00, 1'b1, 1'b1, "AA==");     // zero sextets still pad as usual
    add_row(8'hFF, 1'b1, 1'b1, "/w==");
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, "//8=");
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, "////");
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, "AAAA");     // all-zero full group, no pad
    add_row(8'hFB, 1'b0, 1'b0, '0);
    add_row(8'hEF, 1'b0, 1'b0, '0);
    add_row(8'hBE, 1'b1, 1'b1, "++++");     // '+' for sextet 62

    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < directed_rows.size(); r++)
      send_byte(directed_rows[r].data, directed_rows[r].last, directed_rows[r].typed,
                directed_rows[r].chars);

    // random part: no idling, sender idle, receiver stall, both
    run_phase(0, 0, 110);
    run_phase(60, 0, 110);
    run_phase(0, 60, 110);
    run_phase(24, 24, 110);
    s_tvalid <= 1'b0;

    guard = 0;
    while (pending_chars.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    while (pending_chars.size() != 0) begin
      got_want = pending_chars.pop_front();
      report_mismatch("character never arrived", {1'b0, got_want.ch}, 0);
    end

    $display("Sent %0d bytes in %0d closed groups, checked %0d characters",
             bytes_sent, groups_closed, chars_checked);
    $display("Traffic mixes: free-running, sender idle, receiver stall, both idle");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Timeout waiting on the encoder");
    $display("Regression FAIL");
    $finish;
  end

endmodule
